@@ sv/kptl_pkg.sv @@
// ----------------------------------------------------------------------------
// kptl_pkg
// Shared types and constants for the keyed point tally block: word formats
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package kptl_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;

    localparam int KEY_W    = 24;
    localparam int WEIGHT_W = 8;
    localparam int TOTAL_W  = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic
    {
        MODE_ACCUMULATE = 1'b0,
        MODE_CLEAR      = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic                mode;
        logic [KEY_W-1:0]    key;
        logic [WEIGHT_W-1:0] weight;
    } item_t;

    typedef struct packed
    {
        logic [KEY_W-1:0]   leader_key;
        logic [TOTAL_W-1:0] leader_total;
        logic               dropped;
    } result_t;

    // Controller to datapath.
    typedef struct packed
    {
        logic start;
        logic clear;
        logic scan;
        logic update;
        logic insert;
        logic drop;
        logic publish;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed
    {
        logic req_clear;
        logic req_skip;
        logic match;
        logic scan_done;
        logic full;
    } status_t;

endpackage

@@ sv/kptl_item_if.sv @@
// ----------------------------------------------------------------------------
// kptl_item_if
// Valid/ready channel carrying one input word of the keyed point tally.
// ----------------------------------------------------------------------------
interface kptl_item_if;

    logic            valid;
    logic            ready;
    kptl_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ sv/kptl_result_if.sv @@
// ----------------------------------------------------------------------------
// kptl_result_if
// Valid/ready channel carrying one result word of the keyed point tally.
// ----------------------------------------------------------------------------
interface kptl_result_if;

    logic              valid;
    logic              ready;
    kptl_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ sv/kptl_datapath.sv @@
// ----------------------------------------------------------------------------
// kptl_datapath
// Key and total memories, fill count, scan pointer, leader tracking and the
// result register.
// ----------------------------------------------------------------------------
module kptl_datapath #(
    parameter int TABLE_ENTRIES = kptl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kptl_pkg::item_t   item_data,
    input  kptl_pkg::cmd_t    cmd,
    output kptl_pkg::status_t status,
    output kptl_pkg::result_t result_data
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    logic [kptl_pkg::KEY_W-1:0]   key_mem [TABLE_ENTRIES];
    logic [kptl_pkg::TOTAL_W-1:0] tot_mem [TABLE_ENTRIES];

    logic [kptl_pkg::KEY_W-1:0]    key_reg;
    logic [kptl_pkg::WEIGHT_W-1:0] weight_reg;
    logic [CNT_W-1:0]              used_reg, used_next;
    logic [CNT_W-1:0]              ptr_reg, ptr_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [kptl_pkg::KEY_W-1:0]    rd_key_reg;
    logic [kptl_pkg::TOTAL_W-1:0]  rd_tot_reg;
    logic [IDX_W-1:0]              rd_slot_reg;
    logic [IDX_W-1:0]              leader_slot_reg, leader_slot_next;
    logic [kptl_pkg::KEY_W-1:0]    leader_key_reg, leader_key_next;
    logic [kptl_pkg::TOTAL_W-1:0]  leader_total_reg, leader_total_next;
    logic                          dropped_reg;
    kptl_pkg::result_t             result_reg;

    logic                          issue;
    logic                          match;
    logic [kptl_pkg::TOTAL_W:0]    sum;
    logic [kptl_pkg::TOTAL_W-1:0]  sat_total;
    logic [IDX_W-1:0]              ins_slot;
    logic [IDX_W-1:0]              cand_slot;
    logic [kptl_pkg::TOTAL_W-1:0]  cand_total;
    logic [kptl_pkg::KEY_W-1:0]    cand_key;
    logic                          take;

    assign match    = rd_vld_reg && (rd_key_reg == key_reg);
    assign issue    = cmd.scan && (ptr_reg < used_reg) && !match;
    assign ins_slot = used_reg[IDX_W-1:0];

    assign sum       = {1'b0, rd_tot_reg} + (kptl_pkg::TOTAL_W + 1)'(weight_reg);
    assign sat_total = sum[kptl_pkg::TOTAL_W] ? kptl_pkg::TOTAL_MAX
                                              : sum[kptl_pkg::TOTAL_W-1:0];

    // Totals only grow, so the leader is the old leader or the slot just touched.
    // The later slot wins a tie, which also keeps the leader when it grows itself.
    assign cand_slot  = cmd.update ? rd_slot_reg : ins_slot;
    assign cand_total = cmd.update ? sat_total : kptl_pkg::TOTAL_W'(weight_reg);
    assign cand_key   = cmd.update ? rd_key_reg : key_reg;
    assign take       = (cand_total > leader_total_reg) ||
                        ((cand_total == leader_total_reg) && (cand_slot >= leader_slot_reg));

    assign status.req_clear = (item_data.mode == kptl_pkg::MODE_CLEAR);
    assign status.req_skip  = (item_data.weight == '0);
    assign status.match     = match;
    assign status.scan_done = !(ptr_reg < used_reg) && !rd_vld_reg;
    assign status.full      = (used_reg == FULL_CNT);

    always_comb
    begin
        used_next         = used_reg;
        ptr_next          = ptr_reg;
        rd_vld_next       = issue;
        leader_slot_next  = leader_slot_reg;
        leader_key_next   = leader_key_reg;
        leader_total_next = leader_total_reg;
        if (cmd.start)
        begin
            ptr_next    = '0;
            rd_vld_next = 1'b0;
            if (cmd.clear)
            begin
                used_next         = '0;
                leader_slot_next  = '0;
                leader_key_next   = '0;
                leader_total_next = '0;
            end
        end
        else if (issue)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
        if (cmd.insert)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        if ((cmd.update || cmd.insert) && take)
        begin
            leader_slot_next  = cand_slot;
            leader_key_next   = cand_key;
            leader_total_next = cand_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            ptr_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            leader_slot_reg  <= '0;
            leader_key_reg   <= '0;
            leader_total_reg <= '0;
        end
        else
        begin
            used_reg         <= used_next;
            ptr_reg          <= ptr_next;
            rd_vld_reg       <= rd_vld_next;
            leader_slot_reg  <= leader_slot_next;
            leader_key_reg   <= leader_key_next;
            leader_total_reg <= leader_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg    <= item_data.key;
            weight_reg <= item_data.weight;
        end
        if (cmd.start)
        begin
            dropped_reg <= 1'b0;
        end
        else if (cmd.drop)
        begin
            dropped_reg <= 1'b1;
        end
        if (cmd.publish)
        begin
            result_reg.leader_key   <= leader_key_reg;
            result_reg.leader_total <= leader_total_reg;
            result_reg.dropped      <= dropped_reg;
        end
    end

    // Table memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            key_mem[ins_slot] <= key_reg;
            tot_mem[ins_slot] <= kptl_pkg::TOTAL_W'(weight_reg);
        end
        else if (cmd.update)
        begin
            tot_mem[rd_slot_reg] <= sat_total;
        end
        if (issue)
        begin
            rd_key_reg  <= key_mem[ptr_reg[IDX_W-1:0]];
            rd_tot_reg  <= tot_mem[ptr_reg[IDX_W-1:0]];
            rd_slot_reg <= ptr_reg[IDX_W-1:0];
        end
    end

    assign result_data = result_reg;

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL_CNT)
        else $error("fill count exceeds table size");

    a_empty_leader: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0) == (leader_total_reg == '0))
        else $error("leader total disagrees with fill count");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (used_reg < FULL_CNT))
        else $error("insert into a full table");

endmodule

@@ sv/kptl_ctrl.sv @@
// ----------------------------------------------------------------------------
// kptl_ctrl
// Sequencer for one word: decide, scan the table, update, insert or drop, and
// hand the result to the output register.
// ----------------------------------------------------------------------------
module kptl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  kptl_pkg::status_t status,
    output kptl_pkg::cmd_t    cmd
);

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_INSERT = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign out_free     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.start   = accept;
        cmd.clear   = accept && status.req_clear;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.req_clear || status.req_skip)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (status.match)
                begin
                    state_next = ST_UPDATE;
                end
                else if (status.scan_done && status.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (status.scan_done)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_publish_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten before it was taken");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item_ready)
        else $error("second word accepted while one is in progress");

endmodule

@@ sv/keyed_point_tally_with_leader_core.sv @@
// ----------------------------------------------------------------------------
// keyed_point_tally_with_leader_core
// Table of 24-bit keys with saturating 16-bit point totals and a running
// leader, one result word per input word.
// ----------------------------------------------------------------------------
// One word is handled at a time. A clear word or a word with zero weight
// skips the scan and goes straight to publishing its result. An accumulate
// word scans the used slots through the single registered read port of the
// table memory, one slot a cycle. A new key is then inserted, a key that is
// found is updated, and a word that finds the table full is dropped. The
// controller returns to idle, ready for the next word, as the result is
// loaded into the output register. The leader is kept up to date as totals
// change, so no second pass is needed.
// Clearing takes no sweep: the fill count alone marks which slots hold data.
// The output register lets the next word be accepted while a result waits.
module keyed_point_tally_with_leader_core #(
    parameter int TABLE_ENTRIES = kptl_pkg::TABLE_ENTRIES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    kptl_item_if.sink    item,
    kptl_result_if.source result
);

    kptl_pkg::cmd_t    cmd;
    kptl_pkg::status_t status;

    kptl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    kptl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_data   (item.data),
        .cmd         (cmd),
        .status      (status),
        .result_data (result.data)
    );

endmodule

@@ test/tb_keyed_point_tally_with_leader_core.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_point_tally_with_leader_core
// Self-checking bench for the keyed point tally. A local copy of the slot
// table predicts the leader word for each accepted input word. Directed tests
// cover the edge cases, and random phases vary the key pool and the handshake
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_keyed_point_tally_with_leader_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = kptl_pkg::TABLE_ENTRIES_DEF;
    localparam int KEY_W        = kptl_pkg::KEY_W;
    localparam int WEIGHT_W     = kptl_pkg::WEIGHT_W;
    localparam int TOTAL_W      = kptl_pkg::TOTAL_W;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = kptl_pkg::TOTAL_MAX;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = SLOTS + 20;
    localparam int REPORT_MAX   = 10;

    typedef kptl_pkg::item_t   item_t;
    typedef kptl_pkg::result_t result_t;
    typedef kptl_pkg::mode_t   mode_t;

    logic clk;
    logic rst_n;

    kptl_item_if   item_if();
    kptl_result_if result_if();

    keyed_point_tally_with_leader_core #(
        .TABLE_ENTRIES(SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    // Local copy of the slot table.
    logic [KEY_W-1:0]   slot_key   [SLOTS];
    logic [TOTAL_W-1:0] slot_total [SLOTS];
    int                 slots_used;

    result_t            expected_leaders[$];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_request;
    int                 hold_left;
    logic [KEY_W-1:0]   key_pool[256];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic item_t make_word(input mode_t m, input logic [KEY_W-1:0] k,
                                        input logic [WEIGHT_W-1:0] w);
        item_t it;
        it.mode   = m;
        it.key    = k;
        it.weight = w;
        return it;
    endfunction

    // Applies one word to the local table and returns the leader word it causes.
    function automatic result_t tally_predict(input item_t w);
        result_t     r;
        int          s;
        int          best;
        bit          hit;
        logic [16:0] sum;
        r   = '0;
        hit = 1'b0;
        if (mode_t'(w.mode) == kptl_pkg::MODE_CLEAR)
        begin
            slots_used = 0;
        end
        else if (w.weight != '0)
        begin
            for (s = 0; s < slots_used; s++)
            begin
                if (!hit && slot_key[s] == w.key)
                begin
                    sum           = {1'b0, slot_total[s]} + w.weight;
                    slot_total[s] = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
                    hit           = 1'b1;
                end
            end
            if (!hit)
            begin
                if (slots_used >= SLOTS)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    slot_key[slots_used]   = w.key;
                    slot_total[slots_used] = TOTAL_W'(w.weight);
                    slots_used++;
                end
            end
        end
        // Ties go to the later slot.
        best = 0;
        for (s = 0; s < slots_used; s++)
        begin
            if (slot_total[s] >= slot_total[best])
                best = s;
        end
        if (slots_used != 0)
        begin
            r.leader_key   = slot_key[best];
            r.leader_total = slot_total[best];
        end
        return r;
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic send_word(input item_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= w;
        do
            @(posedge clk);
        while (!item_if.ready);
        expected_leaders.push_back(tally_predict(w));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (expected_leaders.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed();
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h123456, 8'h00));  // zero weight, empty
        send_word(make_word(kptl_pkg::MODE_CLEAR, 24'hFFFFFF, 8'hFF));       // clear on empty
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h000000, 8'h01));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hFFFFFF, 8'hFF));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hFFFFFF, 8'h00));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h800001, 8'hFF));  // tie, later slot
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h000000, 8'hFE));  // tie, earlier slot
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h000000, 8'h01));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h5A5A5A, 8'h80));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hA5A5A5, 8'h7F));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hA5A5A5, 8'h55));
        send_word(make_word(kptl_pkg::MODE_CLEAR, 24'h5A5A5A, 8'h00));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h5A5A5A, 8'h00));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h5A5A5A, 8'hAA));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h000001, 8'hAA));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h5A5A5A, 8'h01));
        send_word(make_word(kptl_pkg::MODE_CLEAR, 24'h000000, 8'h00));
        wait_drained();
    endtask

    task automatic test_table_full();
        int i;
        for (i = 0; i < SLOTS; i++)
            send_word(make_word(kptl_pkg::MODE_ACCUMULATE, KEY_W'(i * 24'h9E3779),
                                WEIGHT_W'($urandom_range(1, 255))));
        for (i = 0; i < 4; i++)
            send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hF00000 | KEY_W'(i),
                                WEIGHT_W'($urandom_range(1, 255))));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hF00010, 8'h00));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE,
                            KEY_W'((SLOTS - 1) * 24'h9E3779), 8'hFF));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h000000, 8'hFF));
        send_word(make_word(kptl_pkg::MODE_CLEAR, 24'h000000, 8'h00));
        wait_drained();
    endtask

    task automatic test_saturation();
        int i;
        for (i = 0; i < 260; i++)
            send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h00FF00, 8'hFF));
        // The second key reaches the cap too, so the later slot must lead.
        for (i = 0; i < 260; i++)
            send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'hFF00FF, 8'hFF));
        send_word(make_word(kptl_pkg::MODE_ACCUMULATE, 24'h00FF00, 8'h01));
        send_word(make_word(kptl_pkg::MODE_CLEAR, 24'h00FF00, 8'hFF));
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        @(negedge clk);
        for (i = 0; i < 30; i++)
            send_word(make_word(kptl_pkg::MODE_ACCUMULATE, key_pool[$urandom_range(0, 15)],
                                WEIGHT_W'($urandom)));
        // The sender pauses here until every leader word is back.
        wait_drained();
    endtask

    task automatic test_random(input int count, input int pool_size, input int clear_pct);
        int    i;
        int    r;
        item_t w;
        for (i = 0; i < 256; i++)
            key_pool[i] = KEY_W'($urandom);
        for (i = 0; i < count; i++)
        begin
            r        = $urandom_range(0, 99);
            w.mode   = (r < clear_pct) ? kptl_pkg::MODE_CLEAR : kptl_pkg::MODE_ACCUMULATE;
            w.key    = (r >= 90) ? KEY_W'($urandom) : key_pool[$urandom_range(0, pool_size - 1)];
            r        = $urandom_range(0, 9);
            w.weight = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : WEIGHT_W'($urandom_range(1, 255));
            send_word(w);
        end
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        result_if.ready = 1'b0;
        hold_left       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Result checking and the stall watchdog.
    initial
    begin
        result_t want;
        result_t got;
        int      quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else if (rst_n && result_if.valid && result_if.ready)
            begin
                got = result_if.data;
                if (expected_leaders.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result word: key %h total %0d dropped %0b",
                                 got.leader_key, got.leader_total, got.dropped);
                end
                else
                begin
                    want = expected_leaders.pop_front();
                    if (got.leader_key !== want.leader_key ||
                        got.leader_total !== want.leader_total ||
                        got.dropped !== want.dropped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"mismatch: key exp %h got %h, total exp %0d got %0d, ",
                                      "dropped exp %0b got %0b"},
                                     want.leader_key, got.leader_key, want.leader_total,
                                     got.leader_total, want.dropped, got.dropped);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        item_if.valid  = 1'b0;
        item_if.data   = '0;
        slots_used     = 0;
        mismatch_count = 0;
        hold_request   = 0;
        set_idling(22, 77);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_random(50, 200, 0);
        test_backpressure();
        set_idling(77, 22);
        test_saturation();
        test_random(50, 24, 2);
        set_idling(0, 0);
        test_random(50, 64, 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_leaders.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
